FILE: rtl/core/sssc_pkg.sv
`timescale 1ns / 1ps
package sssc_pkg;

   localparam int unsigned FIXED_POINT_SCALE = 1000000;
   localparam int unsigned MAX_BYTES = 6;
   localparam int unsigned DATA_W = 8 * MAX_BYTES;
   localparam int unsigned PADDR_W = 5;

   // register indexes
   localparam logic [2:0] REG_MODE     = 3'd0;
   localparam logic [2:0] REG_SAMP_INT = 3'd1;
   localparam logic [2:0] REG_REP_INT  = 3'd2;
   localparam logic [2:0] REG_SCALE    = 3'd3;
   localparam logic [2:0] REG_OFFSET   = 3'd4;
   localparam logic [2:0] REG_DECIMALS = 3'd5;
   localparam logic [2:0] REG_FORMAT   = 3'd6;
   localparam logic [2:0] REG_MASK     = 3'd7;

   // measurement status codes
   localparam logic [1:0] STATUS_PENDING = 2'd0;
   localparam logic [1:0] STATUS_OK      = 2'd1;

   localparam int unsigned DIV_P0 = FIXED_POINT_SCALE / 1;
   localparam int unsigned DIV_P1 = FIXED_POINT_SCALE / 10;
   localparam int unsigned DIV_P2 = FIXED_POINT_SCALE / 100;
   localparam int unsigned DIV_P3 = FIXED_POINT_SCALE / 1000;
   localparam int unsigned DIV_P4 = FIXED_POINT_SCALE / 10000;
   localparam int unsigned DIV_P5 = FIXED_POINT_SCALE / 100000;
   localparam int unsigned DIV_P6 = FIXED_POINT_SCALE / 1000000;

   typedef logic [31:0] word_type;

   function automatic word_type places_divisor(input logic [2:0] p);
      word_type d;
      case (p)
         3'd0:    d = word_type'(DIV_P0);
         3'd1:    d = word_type'(DIV_P1);
         3'd2:    d = word_type'(DIV_P2);
         3'd3:    d = word_type'(DIV_P3);
         3'd4:    d = word_type'(DIV_P4);
         3'd5:    d = word_type'(DIV_P5);
         default: d = word_type'(DIV_P6);
      endcase
      return d;
   endfunction

endpackage

FILE: rtl/core/sssc_if.sv
`timescale 1ns / 1ps
interface sssc_req_if import sssc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [31:0]       now_ms;
   logic              enable_changed;
   logic              enable_state;
   logic [1:0]        measure_status;
   logic [DATA_W-1:0] data_bytes;
   logic [2:0]        data_size;

   modport source (output valid, now_ms, enable_changed, enable_state, measure_status,
                   data_bytes, data_size, input ready);
   modport sink (input valid, now_ms, enable_changed, enable_state, measure_status,
                 data_bytes, data_size, output ready);
endinterface

interface sssc_rsp_if ();
   logic        valid;
   logic        ready;
   logic [31:0] report_value;
   logic        first_report;

   modport source (output valid, report_value, first_report, input ready);
   modport sink (input valid, report_value, first_report, output ready);
endinterface

FILE: rtl/core/sensor_sample_average_scale_core.sv
`timescale 1ns / 1ps
// channel   | direction | handshake           | payload
// req_chan  | in        | valid/ready         | now_ms, enable_changed, enable_state,
//           |           |                     | measure_status, data_bytes, data_size
// rsp_chan  | out       | valid/ready         | report_value, first_report
// APB       | in        | psel/penable/pready | paddr, pwdata, prdata
//
// A tick with no report passes through the decide state back to idle. A report uses
// one 32x32 multiplier three times for the 64-bit product, then a one-bit-per-cycle
// 64-step divider, run once for the decimal scale and, in cumulative mode, once
// before that for the average.
// Reset is synchronous; req ready is high only while the sequencer is idle.
// A finished report waits in the output register; a new tick is taken meanwhile
// and its own report holds until the output register is free.
module sensor_sample_average_scale_core import sssc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   sssc_req_if.sink           req_chan,
   sssc_rsp_if.source         rsp_chan,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [PADDR_W-1:0] paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);
   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_DECIDE = 4'd1;
   localparam logic [3:0] ST_MUL0   = 4'd2;
   localparam logic [3:0] ST_MUL1   = 4'd3;
   localparam logic [3:0] ST_MUL2   = 4'd4;
   localparam logic [3:0] ST_MUL3   = 4'd5;
   localparam logic [3:0] ST_DIVA   = 4'd6;
   localparam logic [3:0] ST_DIVA_W = 4'd7;
   localparam logic [3:0] ST_OFF    = 4'd8;
   localparam logic [3:0] ST_DIVB   = 4'd9;
   localparam logic [3:0] ST_DIVB_W = 4'd10;
   localparam logic [3:0] ST_OUT    = 4'd11;

   logic [2:0]  mode_ff;
   logic [15:0] samp_int_ff;
   logic [25:0] rep_int_ff;
   logic [31:0] scale_ff;
   logic [31:0] offs_ff;
   logic [2:0]  dec_ff;
   logic [10:0] fmt_ff;
   logic [31:0] mask_ff;

   logic [31:0] last_rep_ff, last_rep_in;
   logic [31:0] last_samp_ff, last_samp_in;
   logic [63:0] sum_ff, sum_in;
   logic [31:0] cnt_ff, cnt_in;
   logic        en_ff, en_in;
   logic        sent_ff;

   logic [31:0]       now_ff;
   logic              chg_ff;
   logic              state_bit_ff;
   logic [1:0]        status_ff;
   logic [DATA_W-1:0] bytes_ff;
   logic [2:0]        size_ff;

   logic [3:0]  state_ff, state_in;
   logic        cum_ff, cum_in;
   logic [63:0] opa_ff, opa_in;
   logic [31:0] dv_ff, dv_in;
   logic [63:0] acc_ff;
   logic [63:0] mul_ff;
   logic        neg_ff;

   logic        rsp_valid_ff;
   logic [31:0] rsp_value_ff;
   logic        rsp_first_ff;

   logic [31:0] x_val;
   logic [31:0] gain;
   logic [31:0] gain_hi;
   logic [31:0] mul_a, mul_b;
   logic        cfg_write;
   logic        div_start;
   logic [63:0] div_dividend;
   logic [31:0] div_divisor;
   logic        div_done;
   logic [63:0] div_quo;
   logic [63:0] signed_quo;
   logic        stop;
   logic        go;
   logic        load_out;

   sssc_extract u_extract (
      .data_bytes    (bytes_ff),
      .data_size     (size_ff),
      .format        (fmt_ff),
      .little_endian (mode_ff[2]),
      .mask          (mask_ff),
      .value         (x_val)
   );

   sssc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign gain       = (scale_ff == 32'd0) ? 32'(FIXED_POINT_SCALE) : scale_ff;
   assign gain_hi    = {32{gain[31]}};
   assign cfg_write  = psel && penable && pwrite;
   assign pready     = 1'b1;
   assign signed_quo = neg_ff ? (64'd0 - div_quo) : div_quo;
   assign load_out   = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      case (paddr[PADDR_W-1:2])
         REG_MODE:     prdata = {29'd0, mode_ff};
         REG_SAMP_INT: prdata = {16'd0, samp_int_ff};
         REG_REP_INT:  prdata = {6'd0, rep_int_ff};
         REG_SCALE:    prdata = scale_ff;
         REG_OFFSET:   prdata = offs_ff;
         REG_DECIMALS: prdata = {29'd0, dec_ff};
         REG_FORMAT:   prdata = {21'd0, fmt_ff};
         default:      prdata = mask_ff;
      endcase
   end

   // tick decision: enable switch, sample timer, report timer
   always_comb begin
      last_rep_in  = last_rep_ff;
      last_samp_in = last_samp_ff;
      sum_in       = sum_ff;
      cnt_in       = cnt_ff;
      en_in        = en_ff;
      cum_in       = cum_ff;
      opa_in       = opa_ff;
      dv_in        = dv_ff;
      stop         = 1'b0;
      go           = 1'b0;
      if (state_ff == ST_DECIDE) begin
         cum_in = mode_ff[0];
         if (mode_ff[1]) begin
            if (chg_ff) begin
               en_in       = state_bit_ff;
               last_rep_in = 32'd0;
               if (mode_ff[0]) begin
                  last_samp_in = 32'd0;
                  sum_in       = 64'd0;
                  cnt_in       = 32'd0;
               end
            end
            if (!en_in) begin
               stop = 1'b1;
            end
         end
         if (!stop && mode_ff[0]) begin
            if ((now_ff - last_samp_in) >= {16'd0, samp_int_ff}) begin
               last_samp_in = now_ff;
               if (status_ff == STATUS_PENDING) begin
                  stop = 1'b1;
               end else if (status_ff == STATUS_OK) begin
                  sum_in = sum_in + {{32{x_val[31]}}, x_val};
                  cnt_in = cnt_in + 32'd1;
               end
            end
            if (!stop && (now_ff - last_rep_in) >= {6'd0, rep_int_ff}) begin
               last_rep_in = now_ff;
               if (cnt_in != 32'd0) begin
                  go     = 1'b1;
                  opa_in = sum_in;
                  dv_in  = cnt_in;
                  sum_in = 64'd0;
                  cnt_in = 32'd0;
               end
            end
         end else if (!stop) begin
            if ((now_ff - last_rep_in) >= {6'd0, rep_int_ff} &&
                status_ff != STATUS_PENDING) begin
               last_rep_in = now_ff;
               if (status_ff == STATUS_OK) begin
                  go     = 1'b1;
                  opa_in = {{32{x_val[31]}}, x_val};
               end
            end
         end
      end
   end

   always_comb begin
      case (state_ff)
         ST_MUL0: begin
            mul_a = opa_ff[31:0];
            mul_b = gain;
         end
         ST_MUL1: begin
            mul_a = opa_ff[31:0];
            mul_b = gain_hi;
         end
         default: begin
            mul_a = opa_ff[63:32];
            mul_b = gain;
         end
      endcase
   end

   always_comb begin
      div_start    = 1'b0;
      div_dividend = acc_ff[63] ? (64'd0 - acc_ff) : acc_ff;
      div_divisor  = dv_ff;
      if (state_ff == ST_DIVA) begin
         div_start = 1'b1;
      end else if (state_ff == ST_DIVB) begin
         div_start   = 1'b1;
         div_divisor = places_divisor(dec_ff);
      end else if (state_ff == ST_DIVB_W) begin
         div_divisor = places_divisor(dec_ff);
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_chan.valid) state_in = ST_DECIDE;
         ST_DECIDE: state_in = go ? ST_MUL0 : ST_IDLE;
         ST_MUL0:   state_in = ST_MUL1;
         ST_MUL1:   state_in = ST_MUL2;
         ST_MUL2:   state_in = ST_MUL3;
         ST_MUL3:   state_in = cum_ff ? ST_DIVA : ST_OFF;
         ST_DIVA:   state_in = ST_DIVA_W;
         ST_DIVA_W: if (div_done) state_in = ST_OFF;
         ST_OFF:    state_in = ST_DIVB;
         ST_DIVB:   state_in = ST_DIVB_W;
         ST_DIVB_W: if (div_done) state_in = ST_OUT;
         ST_OUT:    if (load_out) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= 3'd0;
         samp_int_ff  <= 16'd0;
         rep_int_ff   <= 26'd0;
         scale_ff     <= 32'(FIXED_POINT_SCALE);
         offs_ff      <= 32'd0;
         dec_ff       <= 3'd0;
         fmt_ff       <= 11'd0;
         mask_ff      <= 32'hFFFF_FFFF;
         last_rep_ff  <= 32'd0;
         last_samp_ff <= 32'd0;
         sum_ff       <= 64'd0;
         cnt_ff       <= 32'd0;
         en_ff        <= 1'b1;
         sent_ff      <= 1'b0;
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cfg_write) begin
            case (paddr[PADDR_W-1:2])
               REG_MODE:     mode_ff     <= pwdata[2:0];
               REG_SAMP_INT: samp_int_ff <= pwdata[15:0];
               REG_REP_INT:  rep_int_ff  <= pwdata[25:0];
               REG_SCALE:    scale_ff    <= pwdata;
               REG_OFFSET:   offs_ff     <= pwdata;
               REG_DECIMALS: dec_ff      <= pwdata[2:0];
               REG_FORMAT:   fmt_ff      <= pwdata[10:0];
               default:      mask_ff     <= pwdata;
            endcase
         end
         last_rep_ff  <= last_rep_in;
         last_samp_ff <= last_samp_in;
         sum_ff       <= sum_in;
         cnt_ff       <= cnt_in;
         en_ff        <= en_in;
         state_ff     <= state_in;
         if (load_out) begin
            sent_ff      <= 1'b1;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         now_ff       <= req_chan.now_ms;
         chg_ff       <= req_chan.enable_changed;
         state_bit_ff <= req_chan.enable_state;
         status_ff    <= req_chan.measure_status;
         bytes_ff     <= req_chan.data_bytes;
         size_ff      <= req_chan.data_size;
      end
      cum_ff <= cum_in;
      opa_ff <= opa_in;
      dv_ff  <= dv_in;
      mul_ff <= {32'd0, mul_a} * {32'd0, mul_b};
      case (state_ff)
         ST_MUL1: acc_ff <= mul_ff;
         ST_MUL2: acc_ff <= acc_ff + {mul_ff[31:0], 32'd0};
         ST_MUL3: acc_ff <= acc_ff + {mul_ff[31:0], 32'd0};
         ST_OFF:  acc_ff <= acc_ff + {{32{offs_ff[31]}}, offs_ff};
         default: begin
            if (state_ff == ST_DIVA_W && div_done) begin
               acc_ff <= signed_quo;
            end
         end
      endcase
      if (state_ff == ST_DIVA || state_ff == ST_DIVB) begin
         neg_ff <= acc_ff[63];
      end
      if (load_out) begin
         rsp_value_ff <= acc_ff[31:0];
         rsp_first_ff <= !sent_ff;
      end
      if (state_ff == ST_DIVB_W && div_done) begin
         acc_ff <= signed_quo;
      end
   end

   assign req_chan.ready        = (state_ff == ST_IDLE);
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.report_value = rsp_value_ff;
   assign rsp_chan.first_report = rsp_first_ff;

   a_accept_decide: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> state_ff == ST_DECIDE)
      else $error("accepted request did not enter decision");

   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIVA_W || state_ff == ST_DIVB_W))
      else $error("divider finished outside a wait state");

   a_avg_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIVA |-> dv_ff != 32'd0)
      else $error("average started with zero sample count");

   a_first_flag: assert property (@(posedge clock) disable iff (reset)
      $rose(sent_ff) |-> rsp_chan.first_report && rsp_chan.valid)
      else $error("first report not flagged");
endmodule

FILE: rtl/core/sssc_extract.sv
`timescale 1ns / 1ps
module sssc_extract import sssc_pkg::*; (
   input  logic [DATA_W-1:0] data_bytes,
   input  logic [2:0]        data_size,
   input  logic [10:0]       format,
   input  logic              little_endian,
   input  logic [31:0]       mask,
   output logic [31:0]       value
);
   logic [2:0]  total;
   logic [2:0]  off;
   logic [2:0]  cnt;
   logic [3:0]  reach;
   logic [2:0]  n;
   logic [3:0]  idx [4];
   logic [7:0]  bytes_arr [MAX_BYTES];
   logic [31:0] gathered;

   always_comb begin
      for (int i = 0; i < MAX_BYTES; i++) begin
         bytes_arr[i] = data_bytes[8*(MAX_BYTES-1-i) +: 8];
      end
      total = (data_size > 3'(MAX_BYTES)) ? 3'(MAX_BYTES) : data_size;
      off   = format[2:0];
      cnt   = format[5:3];
      reach = {1'b0, off} + {1'b0, cnt};
      if (off >= total) begin
         n = 3'd0;
      end else if (cnt == 3'd0 || reach > {1'b0, total}) begin
         n = total - off;
      end else begin
         n = cnt;
      end
      // byte k of the result holds the k-th last gathered byte (big endian) or the k-th gathered byte (little endian)
      for (int k = 0; k < 4; k++) begin
         idx[k] = little_endian ? ({1'b0, off} + 4'(k))
                                : ({1'b0, off} + {1'b0, n} - 4'd1 - 4'(k));
         if (3'(k) < n && idx[k] < 4'(MAX_BYTES)) begin
            gathered[8*k +: 8] = bytes_arr[idx[k][2:0]];
         end else begin
            gathered[8*k +: 8] = 8'd0;
         end
      end
      value = 32'($signed(gathered) >>> format[10:6]) & mask;
   end
endmodule

FILE: rtl/core/sssc_div.sv
`timescale 1ns / 1ps
module sssc_div import sssc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [63:0] quotient
);
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [5:0]  step_ff, step_in;
   logic [31:0] rem_ff, rem_in;
   logic [63:0] quo_ff, quo_in;
   logic [32:0] trial;
   logic        fits;

   always_comb begin
      trial   = {rem_ff, quo_ff[63]};
      fits    = trial >= {1'b0, divisor};
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = 6'd0;
         rem_in  = 32'd0;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in  = fits ? 32'(trial - {1'b0, divisor}) : trial[31:0];
         quo_in  = {quo_ff[62:0], fits};
         step_in = step_ff + 6'd1;
         if (step_ff == 6'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= 6'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule
